// File: hw/rtl/lbprm_pkg.sv
`timescale 1ns / 1ps

package lbprm_pkg;

  // Default geometry
  localparam int unsigned MaxWidthDef  = 256;
  localparam int unsigned PixelBitsDef = 8;

  // Row counting covers images up to this many rows
  localparam int unsigned HeightLimit = 256;
  localparam int unsigned RowBits     = 8;

  // Smallest legal image side
  localparam int unsigned MinSide = 3;

  // Configuration port
  localparam int unsigned CfgDataBits  = 9;
  localparam int unsigned CfgIndexBits = 2;
  localparam logic [CfgIndexBits-1:0] RegImageWidth  = 2'd0;
  localparam logic [CfgIndexBits-1:0] RegImageHeight = 2'd1;

  // Fixed payload widths
  localparam int unsigned PixelPortBits = 8;
  localparam int unsigned CodeBits      = 8;

  // Output buffer
  localparam int unsigned ObufDepth = 8;

  // One result beat
  typedef struct packed {
    logic [CodeBits-1:0] code;
    logic                row_end;
    logic                image_end;
  } out_beat_t;

  // Largest of the eight rotations of an 8-bit pattern
  function automatic logic [CodeBits-1:0] rot_max(input logic [CodeBits-1:0] pat);
    logic [CodeBits-1:0] best;
    logic [CodeBits-1:0] rot;
    best = pat;
    rot  = pat;
    for (int k = 1; k < CodeBits; k++) begin
      rot = {rot[CodeBits-2:0], rot[CodeBits-1]};
      if (rot > best) begin
        best = rot;
      end
    end
    return best;
  endfunction

endpackage

// File: hw/rtl/lbprm_code.sv
`timescale 1ns / 1ps

// Two-stage pattern unit: neighbour compares, then rotation maximum.
module lbprm_code #(
  parameter int unsigned PIXEL_BITS = lbprm_pkg::PixelBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          win_valid_i,
  input  logic [8:0][PIXEL_BITS-1:0]    win_i,
  input  logic                          row_end_i,
  input  logic                          image_end_i,
  output logic                          push_o,
  output lbprm_pkg::out_beat_t          beat_o,
  output logic [1:0]                    busy_o
);

  // Window slots (row*3+col) visited clockwise from top-left
  localparam int unsigned NbIdx [8] = '{0, 1, 2, 5, 8, 7, 6, 3};

  logic [lbprm_pkg::CodeBits-1:0] pat_d;
  logic [lbprm_pkg::CodeBits-1:0] pat_q;
  logic                           pat_valid_q;
  logic                           pat_row_end_q;
  logic                           pat_image_end_q;
  logic                           push_q;
  lbprm_pkg::out_beat_t           beat_q;

  // Neighbour >= center, first neighbour lands in the MSB
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      pat_d[7-k] = (win_i[NbIdx[k]] >= win_i[4]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_valid_q <= 1'b0;
      push_q      <= 1'b0;
    end else begin
      pat_valid_q <= win_valid_i;
      push_q      <= pat_valid_q;
    end
  end

  // Payload stages
  always_ff @(posedge clk_i) begin
    if (win_valid_i) begin
      pat_q           <= pat_d;
      pat_row_end_q   <= row_end_i;
      pat_image_end_q <= image_end_i;
    end
    if (pat_valid_q) begin
      beat_q.code      <= lbprm_pkg::rot_max(pat_q);
      beat_q.row_end   <= pat_row_end_q;
      beat_q.image_end <= pat_image_end_q;
    end
  end

  assign push_o = push_q;
  assign beat_o = beat_q;
  assign busy_o = {1'b0, pat_valid_q} + {1'b0, push_q};

endmodule

// File: hw/rtl/lbprm_obuf.sv
`timescale 1ns / 1ps

// Small result queue; the input side reserves space before it takes a pixel.
module lbprm_obuf #(
  parameter int unsigned DEPTH = lbprm_pkg::ObufDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  lbprm_pkg::out_beat_t          beat_i,
  input  logic                          pop_i,
  output logic                          valid_o,
  output lbprm_pkg::out_beat_t          beat_o,
  output logic [$clog2(DEPTH+1)-1:0]    count_o
);

  localparam int unsigned PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(DEPTH+1);
  localparam logic [PtrBits-1:0] PtrLast = PtrBits'(DEPTH - 1);

  lbprm_pkg::out_beat_t slots_q [DEPTH];
  logic [PtrBits-1:0]   wr_ptr_q;
  logic [PtrBits-1:0]   rd_ptr_q;
  logic [CntBits-1:0]   count_q;
  logic [CntBits-1:0]   count_d;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CntBits'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntBits'(1);
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrBits'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= beat_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign beat_o  = slots_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

// File: hw/rtl/lbp_rotation_max_3x3.sv
`timescale 1ns / 1ps

// Channel | direction | handshake              | payload
// in      | input     | in_valid_i / in_stall_o  | pixel_i
// out     | output    | out_valid_o / out_stall_i| pattern_code_o, row_end_o, image_end_o
// cfg     | input     | cfg_we_i                 | cfg_index_i, cfg_wdata_i
//
// One pixel per cycle while in_stall_o is low. A result reaches the queue through the registered
// steps line store read, window shift and write-back, compare, rotation maximum.
// The line store is one memory word per column holding the two prior rows;
// it is not cleared at reset (no clearing pass). Counters, window and queue reset.
// in_stall_o rises when the queue fill plus the patterns in flight reaches the queue depth.
module lbp_rotation_max_3x3 #(
  parameter int unsigned MAX_WIDTH  = lbprm_pkg::MaxWidthDef,
  parameter int unsigned PIXEL_BITS = lbprm_pkg::PixelBitsDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [lbprm_pkg::PixelPortBits-1:0]   pixel_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [lbprm_pkg::CodeBits-1:0]        pattern_code_o,
  output logic                                  row_end_o,
  output logic                                  image_end_o,
  input  logic                                  cfg_we_i,
  input  logic [lbprm_pkg::CfgIndexBits-1:0]    cfg_index_i,
  input  logic [lbprm_pkg::CfgDataBits-1:0]     cfg_wdata_i
);

  localparam int unsigned ColBits  = $clog2(MAX_WIDTH);
  localparam int unsigned RowBits  = lbprm_pkg::RowBits;
  localparam int unsigned PxUse    = (PIXEL_BITS < lbprm_pkg::PixelPortBits) ?
                                     PIXEL_BITS : lbprm_pkg::PixelPortBits;
  localparam int unsigned WordBits = 2 * PIXEL_BITS;
  localparam int unsigned CntBits  = $clog2(lbprm_pkg::ObufDepth + 1);
  localparam int unsigned SumBits  = CntBits + 2;
  localparam int unsigned WideBits = 32;
  localparam logic [ColBits-1:0] WlastRst =
    ColBits'(((MAX_WIDTH < 256) ? MAX_WIDTH : 256) - 1);
  localparam logic [RowBits-1:0] HlastRst = RowBits'(lbprm_pkg::HeightLimit - 1);

  // Geometry (stored as last column / last row) and position counters
  logic [ColBits-1:0] wlast_q, wlast_d;
  logic [RowBits-1:0] hlast_q, hlast_d;
  logic [ColBits-1:0] col_q, col_d;
  logic [RowBits-1:0] row_q, row_d;

  logic               in_accept;
  logic [PIXEL_BITS-1:0] px;
  logic               col_end;
  logic               row_last;

  // Line store: {two rows up, one row up} per column
  logic [WordBits-1:0] line_mem [MAX_WIDTH];
  logic [WordBits-1:0] rd_q;

  // Stage 1: pixel waits for its line store word
  logic                  s1_valid_q;
  logic                  s1_out_q;
  logic                  s1_row_end_q;
  logic                  s1_image_end_q;
  logic [PIXEL_BITS-1:0] s1_px_q;
  logic [ColBits-1:0]    s1_col_q;

  // Stage 2: 3x3 window, slot row*3+col, column 2 newest
  logic [8:0][PIXEL_BITS-1:0] win_q;
  logic                       win_valid_q;
  logic                       win_row_end_q;
  logic                       win_image_end_q;

  logic                    push;
  lbprm_pkg::out_beat_t    push_beat;
  logic [1:0]              code_busy;
  lbprm_pkg::out_beat_t    head_beat;
  logic [CntBits-1:0]      obuf_count;
  logic                    out_pop;
  logic [SumBits-1:0]      reserved;

  // Clamp a written side length into its legal range
  always_comb begin
    logic [WideBits-1:0] v;
    logic [WideBits-1:0] wmax;
    v       = WideBits'(cfg_wdata_i);
    wmax    = WideBits'(MAX_WIDTH);
    wlast_d = wlast_q;
    hlast_d = hlast_q;
    if (v < WideBits'(lbprm_pkg::MinSide)) begin
      v = WideBits'(lbprm_pkg::MinSide);
    end
    if (cfg_we_i && (cfg_index_i == lbprm_pkg::RegImageWidth)) begin
      wlast_d = (v > wmax) ? ColBits'(wmax - 1) : ColBits'(v - 1);
    end
    if (cfg_we_i && (cfg_index_i == lbprm_pkg::RegImageHeight)) begin
      hlast_d = (v > WideBits'(lbprm_pkg::HeightLimit)) ?
                RowBits'(lbprm_pkg::HeightLimit - 1) : RowBits'(v - 1);
    end
  end

  assign in_accept = in_valid_i && !in_stall_o;
  assign px        = PIXEL_BITS'(pixel_i[PxUse-1:0]);
  assign col_end   = (col_q == wlast_q);
  assign row_last  = (row_q == hlast_q);

  // Raster position; a register write restarts the image
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_accept) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + RowBits'(1);
      end else begin
        col_d = col_q + ColBits'(1);
      end
    end
    if (cfg_we_i && ((cfg_index_i == lbprm_pkg::RegImageWidth) ||
                     (cfg_index_i == lbprm_pkg::RegImageHeight))) begin
      col_d = '0;
      row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q     <= WlastRst;
      hlast_q     <= HlastRst;
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      s1_out_q    <= 1'b0;
      win_valid_q <= 1'b0;
      win_q       <= '0;
    end else begin
      wlast_q     <= wlast_d;
      hlast_q     <= hlast_d;
      col_q       <= col_d;
      row_q       <= row_d;
      s1_valid_q  <= in_accept;
      s1_out_q    <= in_accept && (row_q >= RowBits'(2)) && (col_q >= ColBits'(2));
      win_valid_q <= s1_valid_q && s1_out_q;
      // Window shift with the fresh column
      if (s1_valid_q) begin
        for (int i = 0; i < 3; i++) begin
          win_q[i*3]   <= win_q[i*3+1];
          win_q[i*3+1] <= win_q[i*3+2];
        end
        win_q[2] <= rd_q[WordBits-1:PIXEL_BITS];
        win_q[5] <= rd_q[PIXEL_BITS-1:0];
        win_q[8] <= s1_px_q;
      end
    end
  end

  // Stage 1 and window payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_px_q        <= px;
      s1_col_q       <= col_q;
      s1_row_end_q   <= col_end;
      s1_image_end_q <= col_end && row_last;
    end
    if (s1_valid_q) begin
      win_row_end_q   <= s1_row_end_q;
      win_image_end_q <= s1_image_end_q;
    end
  end

  // Line store: read on accept, write back in the next cycle (other column)
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rd_q <= line_mem[col_q];
    end
    if (s1_valid_q) begin
      line_mem[s1_col_q] <= {rd_q[PIXEL_BITS-1:0], s1_px_q};
    end
  end

  lbprm_code #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_code (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .win_valid_i (win_valid_q),
    .win_i       (win_q),
    .row_end_i   (win_row_end_q),
    .image_end_i (win_image_end_q),
    .push_o      (push),
    .beat_o      (push_beat),
    .busy_o      (code_busy)
  );

  assign out_pop = out_valid_o && !out_stall_i;

  lbprm_obuf #(
    .DEPTH (lbprm_pkg::ObufDepth)
  ) u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .beat_i  (push_beat),
    .pop_i   (out_pop),
    .valid_o (out_valid_o),
    .beat_o  (head_beat),
    .count_o (obuf_count)
  );

  // Queue slots already filled or promised to patterns in flight
  assign reserved = SumBits'(obuf_count) + SumBits'(code_busy) +
                    SumBits'(s1_valid_q && s1_out_q) + SumBits'(win_valid_q);
  assign in_stall_o = (reserved >= SumBits'(lbprm_pkg::ObufDepth));

  assign pattern_code_o = head_beat.code;
  assign row_end_o      = head_beat.row_end;
  assign image_end_o    = head_beat.image_end;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned LineCols    = lbprm_pkg::MaxWidthDef;
  localparam int unsigned ItemsGoal   = 1650;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RunLimitNs  = 5_000_000;

  // indexes past the register list; writes there are dropped
  localparam logic [lbprm_pkg::CfgIndexBits-1:0] RegSpareA = 2'd2;
  localparam logic [lbprm_pkg::CfgIndexBits-1:0] RegSpareB = 2'd3;

  typedef enum logic [1:0] {RowCfg, RowPixel, RowPixelKnown} plan_kind_e;
  typedef enum logic [1:0] {PixAny, PixNear, PixBinary} pix_mix_e;
  typedef enum logic [2:0] {StallNone, StallSparse, StallMask, StallHeavy, StallHold} stall_mode_e;

  typedef struct {
    plan_kind_e                         kind;
    logic [lbprm_pkg::CfgIndexBits-1:0] idx;
    logic [lbprm_pkg::CfgDataBits-1:0]  val;
    lbprm_pkg::out_beat_t               want;
  } plan_row_t;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                in_valid_i;
  logic                                in_stall_o;
  logic [lbprm_pkg::PixelPortBits-1:0] pixel_i;
  logic                                out_valid_o;
  logic                                out_stall_i;
  logic [lbprm_pkg::CodeBits-1:0]      pattern_code_o;
  logic                                row_end_o;
  logic                                image_end_o;
  logic                                cfg_we_i;
  logic [lbprm_pkg::CfgIndexBits-1:0]  cfg_index_i;
  logic [lbprm_pkg::CfgDataBits-1:0]   cfg_wdata_i;

  // mirror of the block: registers, line store, window, position
  logic [lbprm_pkg::CfgDataBits-1:0] width_reg;
  logic [lbprm_pkg::CfgDataBits-1:0] height_reg;
  logic [7:0]                        line_mem [2*LineCols];
  logic [7:0]                        win [3][3];
  int unsigned                       col_cnt;
  int unsigned                       row_cnt;

  lbprm_pkg::out_beat_t pending_codes [$];
  int unsigned          mismatches;
  int unsigned          pixels_sent;
  int unsigned          burst_left;
  bit                   hold_req;

  plan_row_t plan [33];

  lbp_rotation_max_3x3 DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_i        (pixel_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pattern_code_o (pattern_code_o),
    .row_end_o      (row_end_o),
    .image_end_o    (image_end_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_side(input logic [lbprm_pkg::CfgDataBits-1:0] raw,
                                             input int unsigned hi);
    if (raw < lbprm_pkg::MinSide) return lbprm_pkg::MinSide;
    if (raw > hi) return hi;
    return 32'(raw);
  endfunction

  // Push one pixel through the mirror; returns 1 when a full window yields a code
  function automatic bit lbp_window_step(input logic [7:0] px,
                                         output lbprm_pkg::out_beat_t beat);
    int unsigned w, h, c, r, i;
    logic [7:0]  top, mid, ctr, pat, rot;
    bit          hit;
    w = clamp_side(width_reg, LineCols);
    h = clamp_side(height_reg, lbprm_pkg::HeightLimit);
    c = (col_cnt >= w) ? w - 1 : col_cnt;
    r = (row_cnt >= h) ? h - 1 : row_cnt;
    // line store: column c holds the two rows above
    mid = line_mem[c];
    top = line_mem[LineCols + c];
    line_mem[LineCols + c] = mid;
    line_mem[c] = px;
    for (i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = px;
    hit = (r >= 2) && (c >= 2);
    beat = '0;
    if (hit) begin
      // neighbours clockwise from top-left, first one in the MSB
      ctr = win[1][1];
      pat = {win[0][0] >= ctr, win[0][1] >= ctr, win[0][2] >= ctr, win[1][2] >= ctr,
             win[2][2] >= ctr, win[2][1] >= ctr, win[2][0] >= ctr, win[1][0] >= ctr};
      rot = pat;
      beat.code = pat;
      for (i = 0; i < 8; i++) begin
        rot = {rot[6:0], rot[7]};
        if (rot > beat.code) beat.code = rot;
      end
      beat.row_end   = (c == w - 1);
      beat.image_end = (c == w - 1) && (r == h - 1);
    end
    if (c + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
      row_cnt = r;
    end
    return hit;
  endfunction

  // Offer one pixel beat and hold it until taken; called at a rising edge
  task automatic offer_pixel(input logic [7:0] px, input bit known,
                             input lbprm_pkg::out_beat_t known_beat);
    lbprm_pkg::out_beat_t beat;
    bit                   taken;
    bit                   hit;
    pixel_i    <= px;
    in_valid_i <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = (in_stall_o === 1'b0);
      @(posedge clk_i);
    end
    hit = lbp_window_step(px, beat);
    if (hit || known) pending_codes.push_back(known ? known_beat : beat);
    pixels_sent++;
  endtask

  // Register write once the pipeline has drained
  task automatic write_reg(input logic [lbprm_pkg::CfgIndexBits-1:0] idx,
                           input logic [lbprm_pkg::CfgDataBits-1:0] val);
    in_valid_i <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == lbprm_pkg::RegImageWidth || idx == lbprm_pkg::RegImageHeight) begin
      if (idx == lbprm_pkg::RegImageWidth) width_reg = val;
      else height_reg = val;
      col_cnt = 0;
      row_cnt = 0;
    end
  endtask

  // Random pixels in bursts with random gaps between them
  task automatic stream_pixels(input int unsigned count, input pix_mix_e mix);
    logic [7:0]  base, px;
    int unsigned gap;
    base = 8'($urandom_range(0, 255));
    repeat (count) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160)
                                                 : $urandom_range(1, 16);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      case (mix)
        PixAny:  px = 8'($urandom_range(0, 255));
        PixNear: px = base ^ 8'($urandom_range(0, 3));  // lots of ties with the center
        default: px = {8{$urandom_range(0, 1) == 1}};
      endcase
      offer_pixel(px, 1'b0, '0);
      burst_left--;
    end
  endtask

  // Result checker: a beat is taken at the next rising edge
  always @(negedge clk_i) begin
    lbprm_pkg::out_beat_t want;
    if (rst_ni === 1'b1 && $isunknown(out_valid_o)) begin
      $error("out_valid_o is unknown");
      mismatches++;
    end
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_codes.size() == 0) begin
        $error("result beat with no pattern pending: pattern_code %0h", pattern_code_o);
        mismatches++;
      end else begin
        want = pending_codes.pop_front();
        if (pattern_code_o !== want.code) begin
          $error("pattern_code: expected %0h, got %0h", want.code, pattern_code_o);
          mismatches++;
        end
        if (row_end_o !== want.row_end) begin
          $error("row_end: expected %0b, got %0b", want.row_end, row_end_o);
          mismatches++;
        end
        if (image_end_o !== want.image_end) begin
          $error("image_end: expected %0b, got %0b", want.image_end, image_end_o);
          mismatches++;
        end
      end
    end
  end

  // Receiver stall pattern, with one forced long hold-off early in the random part
  initial begin
    stall_mode_e mode;
    int unsigned span, t;
    logic [7:0]  mask;
    bit          held;
    out_stall_i = 1'b0;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        mode = StallHold;
        span = $urandom_range(200, 400);
      end else if ($urandom_range(0, 15) == 0) begin
        mode = StallHold;
        span = $urandom_range(60, 200);
      end else begin
        mode = stall_mode_e'($urandom_range(0, 3));
        span = $urandom_range(8, 48);
      end
      mask = 8'($urandom_range(0, 255));
      for (t = 0; t < span; t++) begin
        @(posedge clk_i);
        case (mode)
          StallNone:   out_stall_i <= 1'b0;
          StallSparse: out_stall_i <= ($urandom_range(0, 3) == 0);
          StallMask:   out_stall_i <= mask[t % 8];
          StallHeavy:  out_stall_i <= ($urandom_range(0, 3) != 0);
          default:     out_stall_i <= 1'b1;
        endcase
      end
    end
  end

  initial begin
    #(RunLimitNs);
    $display("FAILURE");
    $finish;
  end

  initial begin
    int unsigned phase, n, w_eff, h_eff, split;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    pixel_i     = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    mismatches  = 0;
    pixels_sent = 0;
    burst_left  = 0;
    hold_req    = 1'b0;
    width_reg   = 9'd256;
    height_reg  = 9'd256;
    col_cnt     = 0;
    row_cnt     = 0;
    foreach (line_mem[k]) line_mem[k] = '0;
    foreach (win[i, j]) win[i][j] = '0;

    plan = '{
      // smallest image, flat: every neighbour ties the center
      '{RowCfg, lbprm_pkg::RegImageWidth, 9'd3, '0},
      '{RowCfg, lbprm_pkg::RegImageHeight, 9'd3, '0},
      '{RowPixel, '0, 9'd0, '0}, '{RowPixel, '0, 9'd0, '0},
      '{RowPixel, '0, 9'd0, '0}, '{RowPixel, '0, 9'd0, '0},
      '{RowPixel, '0, 9'd0, '0}, '{RowPixel, '0, 9'd0, '0},
      '{RowPixel, '0, 9'd0, '0}, '{RowPixel, '0, 9'd0, '0},
      '{RowPixelKnown, '0, 9'd0, '{8'hFF, 1'b1, 1'b1}},
      // sides below the minimum clamp to 3; bright center over a dark ring
      '{RowCfg, lbprm_pkg::RegImageWidth, 9'd0, '0},
      '{RowCfg, lbprm_pkg::RegImageHeight, 9'd2, '0},
      '{RowPixel, '0, 9'd0, '0}, '{RowPixel, '0, 9'd0, '0},
      '{RowPixel, '0, 9'd0, '0}, '{RowPixel, '0, 9'd0, '0},
      '{RowPixel, '0, 9'd255, '0},
      '{RowPixel, '0, 9'd0, '0}, '{RowPixel, '0, 9'd0, '0},
      '{RowPixel, '0, 9'd0, '0},
      '{RowPixelKnown, '0, 9'd0, '{8'h00, 1'b1, 1'b1}},
      // writes to spare indexes mid-image must not restart it
      '{RowPixel, '0, 9'd255, '0}, '{RowPixel, '0, 9'd0, '0},
      '{RowPixel, '0, 9'd128, '0}, '{RowPixel, '0, 9'd127, '0},
      '{RowCfg, RegSpareA, 9'h1FF, '0},
      '{RowCfg, RegSpareB, 9'd0, '0},
      '{RowPixel, '0, 9'd255, '0}, '{RowPixel, '0, 9'd1, '0},
      '{RowPixel, '0, 9'd254, '0}, '{RowPixel, '0, 9'd128, '0},
      '{RowPixel, '0, 9'd0, '0}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    foreach (plan[k]) begin
      case (plan[k].kind)
        RowCfg:   write_reg(plan[k].idx, plan[k].val);
        RowPixel: offer_pixel(plan[k].val[7:0], 1'b0, '0);
        default:  offer_pixel(plan[k].val[7:0], 1'b1, plan[k].want);
      endcase
    end

    // three 8x8 images while the receiver holds off for a long stretch
    write_reg(lbprm_pkg::RegImageWidth, 9'd8);
    write_reg(lbprm_pkg::RegImageHeight, 9'd8);
    hold_req = 1'b1;
    stream_pixels(192, PixAny);

    phase = 0;
    while (pixels_sent < ItemsGoal) begin
      phase++;
      case (phase)
        1: begin
          // widest rows, just into the third row
          write_reg(lbprm_pkg::RegImageWidth,
                    $urandom_range(0, 1) ? 9'd256 : 9'($urandom_range(257, 511)));
          write_reg(lbprm_pkg::RegImageHeight, 9'd3);
          n = 2 * LineCols + $urandom_range(3, 60);
        end
        3: begin
          // tallest image, only its first rows
          write_reg(lbprm_pkg::RegImageWidth, 9'd3);
          write_reg(lbprm_pkg::RegImageHeight, 9'd256);
          n = 3 * $urandom_range(6, 20);
        end
        5: begin
          write_reg(lbprm_pkg::RegImageHeight, 9'($urandom_range(257, 511)));
          write_reg(lbprm_pkg::RegImageWidth, 9'($urandom_range(3, 6)));
          n = $urandom_range(20, 80);
        end
        default: begin
          case ($urandom_range(0, 3))
            0: write_reg(lbprm_pkg::RegImageWidth, 9'($urandom_range(0, 12)));
            1: write_reg(lbprm_pkg::RegImageHeight, 9'($urandom_range(0, 8)));
            default: begin
              case ($urandom_range(0, 9))
                0:       write_reg(lbprm_pkg::RegImageWidth, 9'($urandom_range(0, 2)));
                1:       write_reg(lbprm_pkg::RegImageWidth, 9'($urandom_range(13, 40)));
                default: write_reg(lbprm_pkg::RegImageWidth, 9'($urandom_range(3, 12)));
              endcase
              write_reg(lbprm_pkg::RegImageHeight, ($urandom_range(0, 5) == 0)
                                                   ? 9'($urandom_range(0, 2))
                                                   : 9'($urandom_range(3, 8)));
            end
          endcase
          w_eff = clamp_side(width_reg, LineCols);
          h_eff = clamp_side(height_reg, lbprm_pkg::HeightLimit);
          n = w_eff * h_eff * ((w_eff * h_eff < 60) ? $urandom_range(1, 3) : 1);
          if ($urandom_range(0, 2) == 0) n += $urandom_range(0, w_eff * h_eff - 1);
        end
      endcase
      // now and then a spare-index write lands mid-image
      split = ($urandom_range(0, 4) == 0 && n > 1) ? $urandom_range(1, n - 1) : 0;
      if (split != 0) begin
        stream_pixels(split, pix_mix_e'($urandom_range(0, 2)));
        write_reg($urandom_range(0, 1) ? RegSpareA : RegSpareB, 9'($urandom_range(0, 511)));
        n -= split;
      end
      stream_pixels(n, pix_mix_e'($urandom_range(0, 2)));
    end

    in_valid_i <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/lbprm_pkg.sv
hw/rtl/lbprm_code.sv
hw/rtl/lbprm_obuf.sv
hw/rtl/lbp_rotation_max_3x3.sv
verif/testbench.sv
